>>> sv/mtss_pkg.sv
// shared types, codes and constants for the micro tile shape search
package mtss_pkg;

	localparam int DimW   = 9;
	localparam int AreaW  = 16;
	localparam int DivW   = 2 * DimW;
	localparam int StepW  = 5;

	localparam logic [StepW-1:0] STEPS_PROD = StepW'(DivW);
	localparam logic [StepW-1:0] STEPS_DIM  = StepW'(DimW);
	localparam logic [StepW-1:0] STEPS_AREA = StepW'(AreaW);

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_NOFIT    = 3'd3;
	localparam logic [2:0] ST_INCONS   = 3'd4;

	typedef struct packed {
		logic [DimW-1:0]  macro_height;
		logic [DimW-1:0]  macro_width;
		logic [AreaW-1:0] micro_area;
		logic             tall_tile;
	} mtss_in_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [DimW-1:0] micro_height;
		logic [DimW-1:0] micro_width;
	} mtss_out_t;

	typedef enum logic [1:0] {
		DOP_PROD,
		DOP_DIM,
		DOP_AREA,
		DOP_CONS
	} div_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PROD,
		S_CAND,
		S_DIM,
		S_AREA,
		S_CONSST,
		S_CONS,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic       load;
		logic       init_search;
		logic       swap_sel;
		logic       dec_d;
		logic       div_start;
		div_op_t    div_op;
		logic       take_shape;
		logic       set_status;
		logic [2:0] status_code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic area_zero;
		logic d_zero;
		logic div_done;
		logic rem_zero;
		logic quo_fits;
		logic tall;
		logic swap;
	} dp_stat_t;

endpackage

>>> sv/micro_tile_shape_search.sv
// top level of the micro tile shape search: controller plus datapath
// steps: a zero area ends the item; else the macro area must be a multiple of the
//   micro area (else mismatch); candidates count down from the height until one
//   divides it and the micro area with a fitting quotient (else no fit); macro width
//   must divide by the found width (or inconsistent); wide tiles also search by width
// throughput: one item at a time, set by the shared one-bit-per-cycle divider
// reset: arst_n clears the controller to idle; the result beat cannot be stalled
module micro_tile_shape_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mtss_pkg::mtss_in_t  item,
	output logic                busy,
	output logic                done,
	output mtss_pkg::mtss_out_t result
);
	import mtss_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	mtss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mtss_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

>>> sv/mtss_div.sv
// iterative restoring divider, one quotient bit per cycle
module mtss_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mtss_pkg::DivW-1:0]  dividend,
	input  logic [mtss_pkg::AreaW-1:0] divisor,
	input  logic [mtss_pkg::StepW-1:0] steps,
	output logic                      done,
	output logic [mtss_pkg::DivW-1:0]  quo,
	output logic [mtss_pkg::AreaW-1:0] rem
);
	import mtss_pkg::*;

	logic [DivW-1:0]  sh_q;
	logic [AreaW-1:0] rem_q;
	logic [AreaW-1:0] div_q;
	logic [StepW-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [AreaW:0]   trial;
	logic             ge;
	logic [AreaW:0]   diff;

	always_comb begin
		trial = {rem_q, sh_q[DivW-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == StepW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend arrives left aligned, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			sh_q  <= {sh_q[DivW-2:0], ge};
			rem_q <= ge ? diff[AreaW-1:0] : trial[AreaW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = sh_q;
	assign rem  = rem_q;

endmodule

>>> sv/mtss_dp.sv
// datapath: operand registers, candidate counter, shared divider, result registers
module mtss_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtss_pkg::mtss_in_t   item,
	input  mtss_pkg::ctrl_cmd_t  cmd,
	output mtss_pkg::dp_stat_t   stat,
	output mtss_pkg::mtss_out_t  result
);
	import mtss_pkg::*;

	logic [DimW-1:0]  th_q;
	logic [DimW-1:0]  tw_q;
	logic [AreaW-1:0] ts_q;
	logic             tall_q;
	logic             swap_q;
	logic [DimW-1:0]  d_q;
	logic [DimW-1:0]  h_q;
	logic [DimW-1:0]  w_q;
	logic [2:0]       status_q;

	logic [DimW-1:0]  dim;
	logic [DimW-1:0]  other;
	logic [DivW-1:0]  prod;
	logic [DivW-1:0]  dividend;
	logic [AreaW-1:0] divisor;
	logic [StepW-1:0] steps;
	logic             div_done;
	logic [DivW-1:0]  quo;
	logic [AreaW-1:0] rem;

	assign dim   = swap_q ? tw_q : th_q;
	assign other = swap_q ? th_q : tw_q;
	assign prod  = th_q * tw_q;

	always_comb begin
		case (cmd.div_op)
			DOP_PROD: begin
				dividend = prod;
				divisor  = ts_q;
				steps    = STEPS_PROD;
			end
			DOP_DIM: begin
				dividend = {dim, {(DivW-DimW){1'b0}}};
				divisor  = {{(AreaW-DimW){1'b0}}, d_q};
				steps    = STEPS_DIM;
			end
			DOP_AREA: begin
				dividend = {ts_q, {(DivW-AreaW){1'b0}}};
				divisor  = {{(AreaW-DimW){1'b0}}, d_q};
				steps    = STEPS_AREA;
			end
			default: begin
				// consistency: macro width must be a multiple of the found width
				dividend = {tw_q, {(DivW-DimW){1'b0}}};
				divisor  = {{(AreaW-DimW){1'b0}}, w_q};
				steps    = STEPS_DIM;
			end
		endcase
	end

	mtss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.steps    (steps),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			swap_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				status_q <= ST_OK;
				swap_q   <= 1'b0;
			end
			if (cmd.init_search) begin
				swap_q <= cmd.swap_sel;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			th_q   <= item.macro_height;
			tw_q   <= item.macro_width;
			ts_q   <= item.micro_area;
			tall_q <= item.tall_tile;
		end
		if (cmd.init_search) begin
			d_q <= cmd.swap_sel ? tw_q : th_q;
		end else if (cmd.dec_d) begin
			d_q <= d_q - 1'b1;
		end
		if (cmd.take_shape) begin
			if (swap_q) begin
				w_q <= d_q;
				h_q <= quo[DimW-1:0];
			end else begin
				h_q <= d_q;
				w_q <= quo[DimW-1:0];
			end
		end
	end

	always_comb begin
		stat.area_zero = ts_q == '0;
		stat.d_zero    = d_q == '0;
		stat.div_done  = div_done;
		stat.rem_zero  = rem == '0;
		stat.quo_fits  = quo <= {{(DivW-DimW){1'b0}}, other};
		stat.tall      = tall_q;
		stat.swap      = swap_q;
	end

	always_comb begin
		result.status       = status_q;
		result.micro_height = (status_q == ST_OK) ? h_q : '0;
		result.micro_width  = (status_q == ST_OK) ? w_q : '0;
	end

endmodule

>>> sv/mtss_ctrl.sv
// controller: sequences the area check, the divisor searches and the result beat
module mtss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mtss_pkg::dp_stat_t  stat,
	output mtss_pkg::ctrl_cmd_t cmd,
	output logic                busy,
	output logic                done
);
	import mtss_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = stat.area_zero ? S_DONE : S_PROD;
			end
			S_PROD: begin
				if (stat.div_done) state_d = stat.rem_zero ? S_CAND : S_DONE;
			end
			S_CAND: begin
				state_d = stat.d_zero ? S_DONE : S_DIM;
			end
			S_DIM: begin
				if (stat.div_done) state_d = stat.rem_zero ? S_AREA : S_CAND;
			end
			S_AREA: begin
				if (stat.div_done) begin
					if (stat.rem_zero && stat.quo_fits) begin
						state_d = stat.swap ? S_DONE : S_CONSST;
					end else begin
						state_d = S_CAND;
					end
				end
			end
			S_CONSST: begin
				state_d = S_CONS;
			end
			S_CONS: begin
				if (stat.div_done) begin
					state_d = (!stat.rem_zero || stat.tall) ? S_DONE : S_CAND;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_op = DOP_PROD;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_CHECK: begin
				if (stat.area_zero) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_ZERO;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_PROD;
				end
			end
			S_PROD: begin
				if (stat.div_done) begin
					if (stat.rem_zero) begin
						cmd.init_search = 1'b1;
						cmd.swap_sel    = 1'b0;
					end else begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_MISMATCH;
					end
				end
			end
			S_CAND: begin
				if (stat.d_zero) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_NOFIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_DIM;
				end
			end
			S_DIM: begin
				if (stat.div_done) begin
					if (stat.rem_zero) begin
						cmd.div_start = 1'b1;
						cmd.div_op    = DOP_AREA;
					end else begin
						cmd.dec_d = 1'b1;
					end
				end
			end
			S_AREA: begin
				if (stat.div_done) begin
					if (stat.rem_zero && stat.quo_fits) begin
						cmd.take_shape = 1'b1;
						if (stat.swap) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_OK;
						end
					end else begin
						cmd.dec_d = 1'b1;
					end
				end
			end
			S_CONSST: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DOP_CONS;
			end
			S_CONS: begin
				cmd.div_op = DOP_CONS;
				if (stat.div_done) begin
					if (!stat.rem_zero) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_INCONS;
					end else if (stat.tall) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_OK;
					end else begin
						// wide tile: search again along the width
						cmd.init_search = 1'b1;
						cmd.swap_sel    = 1'b1;
					end
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule

>>> sv/mtss_chk.sv
// port level checker for the micro tile shape search, bound to the top level
module mtss_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input mtss_pkg::mtss_out_t result
);
	import mtss_pkg::*;

	// a result beat only ever closes an item in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted beat did not make the block busy");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("more than one result beat per item");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |->
			result.micro_height == '0 && result.micro_width == '0)
		else $error("failing result carries a shape");

	a_ok_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_OK |->
			result.micro_height != '0 && result.micro_width != '0)
		else $error("ok result with an empty shape");

endmodule

bind micro_tile_shape_search mtss_chk u_mtss_chk (.*);
